[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for the concurrent checks used across the receiver.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge while reset is low.
`define ARP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define ARP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/arp_pkg.sv]
// ----------------------------------------------------------------------------
// arp_pkg
// Shared types and constants of the ArtDMX packet receiver.
// ----------------------------------------------------------------------------
package arp_pkg;

  // Header layout (byte offsets within the UDP payload)
  localparam logic [9:0] POS_OPC_LO = 10'd8;
  localparam logic [9:0] POS_OPC_HI = 10'd9;
  localparam logic [9:0] POS_UNIV   = 10'd14;
  localparam logic [9:0] POS_LEN_HI = 10'd16;
  localparam logic [9:0] POS_LEN_LO = 10'd17;
  localparam logic [9:0] HDR_BYTES  = 10'd18;
  localparam logic [9:0] POS_MAX    = 10'd1023;
  localparam logic [9:0] ID_BYTES   = 10'd8;

  // Opcode 0x5000, sent low byte first
  localparam logic [7:0] OPCODE_LO = 8'h00;
  localparam logic [7:0] OPCODE_HI = 8'h50;

  // "Art-Net" followed by a zero byte
  localparam logic [7:0] ART_ID [8] = '{8'h41, 8'h72, 8'h74, 8'h2D,
                                        8'h4E, 8'h65, 8'h74, 8'h00};

  // Item function codes
  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // Result kinds
  localparam logic KIND_VERDICT = 1'b0;
  localparam logic KIND_READ    = 1'b1;

  // Output queue
  localparam int         OUT_DEPTH = 4;
  localparam int         OUT_PTR_W = 2;
  localparam int         OUT_CNT_W = 3;

  typedef enum logic [2:0] {
    V_OK     = 3'd0,
    V_SHORT  = 3'd1,
    V_ID     = 3'd2,
    V_OPCODE = 3'd3,
    V_LENGTH = 3'd4,
    V_TRUNC  = 3'd5
  } verdict_t;

  typedef struct packed {
    logic       kind;
    verdict_t   verdict;
    logic [3:0] universe;
    logic [9:0] length;
    logic [7:0] value;
  } result_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] universe;
    logic [9:0] length;
  } commit_t;

  typedef struct packed {
    logic       en;
    logic [8:0] index;
    logic [7:0] data;
  } stage_wr_t;

endpackage

[design/arp_parser.sv]
// ----------------------------------------------------------------------------
// arp_parser
// Header checker: walks the payload byte by byte, keeps the first failed
// check, latches universe and channel count, and gives the verdict at the end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module arp_parser #(
  parameter int NUM_UNIVERSES = 16,
  parameter int MAX_CHANNELS  = 512
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  logic [7:0]         byte_in,
  input  logic               eop,
  output logic [3:0]         universe,
  output logic               verdict_valid,
  output arp_pkg::result_t   verdict_res,
  output arp_pkg::commit_t   commit,
  output arp_pkg::stage_wr_t stage_wr
);

  localparam logic [9:0]  MAX_LEN   = 10'(MAX_CHANNELS);
  localparam logic [15:0] MAX_LEN16 = 16'(MAX_CHANNELS);
  localparam logic [4:0]  NUM_UNIV  = 5'(NUM_UNIVERSES);

  logic [9:0]        pos;
  arp_pkg::verdict_t reject;
  logic [3:0]        univ;
  logic [9:0]        len;

  arp_pkg::verdict_t reject_next;
  arp_pkg::verdict_t flag_code;
  arp_pkg::verdict_t verdict;
  logic [3:0]        univ_next;
  logic [9:0]        len_next;
  logic [9:0]        pos_next;
  logic [9:0]        k;
  logic [15:0]       count16;
  logic [10:0]       needed;

  // Check the byte at its header position
  always_comb begin
    flag_code = arp_pkg::V_OK;
    univ_next = univ;
    len_next  = len;
    count16   = {len[7:0], byte_in};
    if (pos < arp_pkg::ID_BYTES) begin
      if (byte_in != arp_pkg::ART_ID[pos[2:0]]) flag_code = arp_pkg::V_ID;
    end else if (pos == arp_pkg::POS_OPC_LO) begin
      if (byte_in != arp_pkg::OPCODE_LO) flag_code = arp_pkg::V_OPCODE;
    end else if (pos == arp_pkg::POS_OPC_HI) begin
      if (byte_in != arp_pkg::OPCODE_HI) flag_code = arp_pkg::V_OPCODE;
    end else if (pos == arp_pkg::POS_UNIV) begin
      univ_next = byte_in[3:0];
    end else if (pos == arp_pkg::POS_LEN_HI) begin
      len_next = {2'b00, byte_in};
    end else if (pos == arp_pkg::POS_LEN_LO) begin
      if (count16 < 16'd2 || count16 > MAX_LEN16) begin
        flag_code = arp_pkg::V_LENGTH;
        len_next  = '0;
      end else begin
        len_next = count16[9:0];
      end
    end
    reject_next = (reject == arp_pkg::V_OK) ? flag_code : reject;
    pos_next    = (pos != arp_pkg::POS_MAX) ? pos + 10'd1 : pos;
  end

  // Route channel bytes to the staging bank
  always_comb begin
    k              = pos - arp_pkg::HDR_BYTES;
    stage_wr.en    = fire && (pos >= arp_pkg::HDR_BYTES) && (reject == arp_pkg::V_OK) &&
                     (k < len) && (k < MAX_LEN);
    stage_wr.index = k[8:0];
    stage_wr.data  = byte_in;
  end

  // Judge the packet at its last byte
  always_comb begin
    needed = {1'b0, arp_pkg::HDR_BYTES} + {1'b0, len_next};
    if (pos_next < arp_pkg::HDR_BYTES) begin
      verdict = arp_pkg::V_SHORT;
    end else if (reject_next != arp_pkg::V_OK) begin
      verdict = reject_next;
    end else if ({1'b0, pos_next} < needed) begin
      verdict = arp_pkg::V_TRUNC;
    end else begin
      verdict = arp_pkg::V_OK;
    end
    verdict_valid        = fire && eop;
    verdict_res.kind     = arp_pkg::KIND_VERDICT;
    verdict_res.verdict  = verdict;
    verdict_res.universe = (verdict == arp_pkg::V_OK) ? univ_next : 4'd0;
    verdict_res.length   = (verdict == arp_pkg::V_OK) ? len_next : 10'd0;
    verdict_res.value    = '0;
    commit.valid         = fire && eop && (verdict == arp_pkg::V_OK) &&
                           ({1'b0, univ_next} < NUM_UNIV);
    commit.universe      = univ_next;
    commit.length        = len_next;
  end

  assign universe = univ;

  // Advance the header state; clear it at the packet end
  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      reject <= arp_pkg::V_OK;
      univ   <= '0;
      len    <= '0;
    end else if (fire) begin
      if (eop) begin
        pos    <= '0;
        reject <= arp_pkg::V_OK;
        univ   <= '0;
        len    <= '0;
      end else begin
        pos    <= pos_next;
        reject <= reject_next;
        univ   <= univ_next;
        len    <= len_next;
      end
    end
  end

  `ARP_ASSERT(a_pos_clear, clk, rst, (fire && eop) |=> (pos == 10'd0), "position not cleared")

endmodule

[design/arp_dir.sv]
// ----------------------------------------------------------------------------
// arp_dir
// Universe directory: maps each universe to a channel bank and its stored
// length, and keeps the spare bank that takes the next packet's channels.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module arp_dir #(
  parameter int NUM_UNIVERSES = 16,
  parameter int UNI_W         = 4,
  parameter int BANK_W        = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [3:0]       a_universe,
  input  logic [3:0]       b_universe,
  input  arp_pkg::commit_t commit,
  output logic [BANK_W-1:0] free_bank,
  output logic [BANK_W-1:0] b_bank,
  output logic [9:0]        b_length
);

  localparam int               DIR_DEPTH = 1 << UNI_W;
  localparam logic [BANK_W-1:0] FREE_INIT = BANK_W'(NUM_UNIVERSES);

  typedef struct packed {
    logic [BANK_W-1:0] bank;
    logic [9:0]        length;
  } dir_entry_t;

  dir_entry_t           dir_mem [DIR_DEPTH];
  logic [DIR_DEPTH-1:0] dir_valid;
  logic [BANK_W-1:0]    free;
  dir_entry_t           rd_a;
  dir_entry_t           rd_b;

  logic [UNI_W-1:0] a_idx;
  logic [UNI_W-1:0] b_idx;
  logic [UNI_W-1:0] c_idx;

  assign a_idx = a_universe[UNI_W-1:0];
  assign b_idx = b_universe[UNI_W-1:0];
  assign c_idx = commit.universe[UNI_W-1:0];

  // Write the committed mapping; read both ports, unwritten entries as reset
  always_ff @(posedge clk) begin
    if (commit.valid) begin
      dir_mem[c_idx] <= '{bank: free, length: commit.length};
    end
    if (dir_valid[a_idx]) begin
      rd_a <= dir_mem[a_idx];
    end else begin
      rd_a <= '{bank: BANK_W'(a_idx), length: 10'd0};
    end
    if (dir_valid[b_idx]) begin
      rd_b <= dir_mem[b_idx];
    end else begin
      rd_b <= '{bank: BANK_W'(b_idx), length: 10'd0};
    end
  end

  // Swap banks on commit: the old bank of the universe becomes spare
  always_ff @(posedge clk) begin
    if (rst) begin
      dir_valid <= '0;
      free      <= FREE_INIT;
    end else if (commit.valid) begin
      dir_valid[c_idx] <= 1'b1;
      free             <= rd_a.bank;
    end
  end

  assign free_bank = free;
  assign b_bank    = rd_b.bank;
  assign b_length  = rd_b.length;

  `ARP_ASSERT(a_swap_distinct, clk, rst, commit.valid |-> (rd_a.bank != free), "spare bank is mapped")

endmodule

[design/arp_bank_mem.sv]
// ----------------------------------------------------------------------------
// arp_bank_mem
// Channel memory holding all universe banks plus the spare bank; one write
// port and one registered read port.
// ----------------------------------------------------------------------------
module arp_bank_mem #(
  parameter int ADDR_W = 14,
  parameter int DEPTH  = 8704
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [DEPTH];

  // Write one channel byte; read one every cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[design/arp_out_fifo.sv]
// ----------------------------------------------------------------------------
// arp_out_fifo
// Result queue between the pipeline and the output handshake.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module arp_out_fifo (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  arp_pkg::result_t              push_data,
  output logic                          pop_valid,
  input  logic                          pop_ready,
  output arp_pkg::result_t              head,
  output logic [arp_pkg::OUT_CNT_W-1:0] count
);

  localparam logic [arp_pkg::OUT_CNT_W-1:0] DEPTH_CNT =
    arp_pkg::OUT_CNT_W'(arp_pkg::OUT_DEPTH);

  arp_pkg::result_t                entries [arp_pkg::OUT_DEPTH];
  logic [arp_pkg::OUT_PTR_W-1:0]   wr_ptr;
  logic [arp_pkg::OUT_PTR_W-1:0]   rd_ptr;
  logic                            pop;

  assign pop_valid = (count != '0);
  assign pop       = pop_valid && pop_ready;
  assign head      = entries[rd_ptr];

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `ARP_ASSERT(a_no_overflow, clk, rst, push |-> ((count < DEPTH_CNT) || pop), "result queue overflow")

endmodule

[design/artdmx_packet_receiver.sv]
// ----------------------------------------------------------------------------
// artdmx_packet_receiver
// ArtDMX receiver: header check, staging into a spare bank, commit by bank
// swap, and channel reads from the universe banks.
// ----------------------------------------------------------------------------
// Path: a result passes pipeline stages 1 and 2, then the result queue, before it is offered.
// Throughput: one word per cycle; the 4-entry result queue and its credit
//   check against the two pipeline stages set the pace when results back up.
// Reset: synchronous; clears the header state, directory valid bits, spare
//   bank pointer, pipeline and queue. Channel memory is not cleared.
module artdmx_packet_receiver #(
  parameter int NUM_UNIVERSES = 16,
  parameter int MAX_CHANNELS  = 512
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  input  logic       func,
  input  logic [7:0] payload_byte,
  input  logic       end_of_packet,
  input  logic [3:0] read_universe,
  input  logic [8:0] read_channel,
  output logic       result_valid,
  input  logic       result_ready,
  output logic       result_kind,
  output logic [2:0] verdict,
  output logic [3:0] packet_universe,
  output logic [9:0] packet_length,
  output logic [7:0] channel_value
);

  localparam int         CH_W      = $clog2(MAX_CHANNELS);
  localparam int         UNI_W     = (NUM_UNIVERSES > 1) ? $clog2(NUM_UNIVERSES) : 1;
  localparam int         BANK_W    = $clog2(NUM_UNIVERSES + 1);
  localparam int         ADDR_W    = BANK_W + CH_W;
  localparam int         MEM_DEPTH = (NUM_UNIVERSES + 1) << CH_W;
  localparam logic [4:0] NUM_UNIV  = 5'(NUM_UNIVERSES);

  logic item_fire;
  logic byte_fire;
  logic read_fire;

  logic [3:0]         parse_universe;
  logic               verdict_valid;
  arp_pkg::result_t   verdict_res;
  arp_pkg::commit_t   commit;
  arp_pkg::stage_wr_t stage_wr;

  logic [BANK_W-1:0] free_bank;
  logic [BANK_W-1:0] b_bank;
  logic [9:0]        b_length;
  logic [7:0]        mem_rd;

  // Pipeline stage 1: verdict or read request
  logic             s1_valid;
  logic             s1_read;
  arp_pkg::result_t s1_res;
  logic [3:0]       s1_universe;
  logic [8:0]       s1_channel;
  logic             s1_hit;

  // Pipeline stage 2: result awaiting channel data
  logic             s2_valid;
  arp_pkg::result_t s2_res;
  logic             s2_hit;
  arp_pkg::result_t push_res;

  arp_pkg::result_t              head;
  logic [arp_pkg::OUT_CNT_W-1:0] fifo_count;
  logic [arp_pkg::OUT_CNT_W-1:0] occupancy;

  // Take a word while the queue has room for everything in flight
  assign occupancy  = fifo_count + arp_pkg::OUT_CNT_W'(s1_valid) +
                      arp_pkg::OUT_CNT_W'(s2_valid);
  assign item_ready = (occupancy < arp_pkg::OUT_CNT_W'(arp_pkg::OUT_DEPTH));
  assign item_fire  = item_valid && item_ready;
  assign byte_fire  = item_fire && (func == arp_pkg::FUNC_BYTE);
  assign read_fire  = item_fire && (func == arp_pkg::FUNC_READ);

  arp_parser #(
    .NUM_UNIVERSES (NUM_UNIVERSES),
    .MAX_CHANNELS  (MAX_CHANNELS)
  ) u_parser (
    .clk           (clk),
    .rst           (rst),
    .fire          (byte_fire),
    .byte_in       (payload_byte),
    .eop           (end_of_packet),
    .universe      (parse_universe),
    .verdict_valid (verdict_valid),
    .verdict_res   (verdict_res),
    .commit        (commit),
    .stage_wr      (stage_wr)
  );

  arp_dir #(
    .NUM_UNIVERSES (NUM_UNIVERSES),
    .UNI_W         (UNI_W),
    .BANK_W        (BANK_W)
  ) u_dir (
    .clk        (clk),
    .rst        (rst),
    .a_universe (parse_universe),
    .b_universe (read_universe),
    .commit     (commit),
    .free_bank  (free_bank),
    .b_bank     (b_bank),
    .b_length   (b_length)
  );

  // Channel hit: stored universe and channel below its stored length
  assign s1_hit = s1_read && ({1'b0, s1_universe} < NUM_UNIV) &&
                  ({1'b0, s1_channel} < b_length);

  arp_bank_mem #(
    .ADDR_W (ADDR_W),
    .DEPTH  (MEM_DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (stage_wr.en),
    .wr_addr ({free_bank, stage_wr.index[CH_W-1:0]}),
    .wr_data (stage_wr.data),
    .rd_addr ({b_bank, s1_channel[CH_W-1:0]}),
    .rd_data (mem_rd)
  );

  // Hold payload through the pipeline
  always_ff @(posedge clk) begin
    if (read_fire) begin
      s1_res      <= '{kind: arp_pkg::KIND_READ, verdict: arp_pkg::V_OK,
                       universe: 4'd0, length: 10'd0, value: 8'd0};
      s1_read     <= 1'b1;
      s1_universe <= read_universe;
      s1_channel  <= read_channel;
    end else begin
      s1_res      <= verdict_res;
      s1_read     <= 1'b0;
      s1_universe <= read_universe;
      s1_channel  <= read_channel;
    end
    s2_res <= s1_res;
    s2_hit <= s1_hit;
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= verdict_valid || read_fire;
      s2_valid <= s1_valid;
    end
  end

  // Merge channel data into a read result
  always_comb begin
    push_res       = s2_res;
    push_res.value = s2_hit ? mem_rd : 8'd0;
  end

  arp_out_fifo u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (s2_valid),
    .push_data (push_res),
    .pop_valid (result_valid),
    .pop_ready (result_ready),
    .head      (head),
    .count     (fifo_count)
  );

  assign result_kind     = head.kind;
  assign verdict         = head.verdict;
  assign packet_universe = head.universe;
  assign packet_length   = head.length;
  assign channel_value   = head.value;

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Streams ArtDMX payload words and channel reads into the receiver, with
// random gaps on both sides. A mirror of the header checks and universe
// banks predicts each verdict and read, and every returned word is compared
// field by field in arrival order.
// ----------------------------------------------------------------------------
module testbench;

  localparam int IDLE_LIMIT    = 2000;
  localparam int TOTAL_WORDS   = 1000;
  localparam int SETTLE_CYCLES = 8;

  // Mirror of the header checker, staging buffer and universe banks
  class universe_mirror;
    logic [9:0]        position;
    arp_pkg::verdict_t reject;
    logic [3:0]        universe;
    logic [9:0]        length;
    logic [7:0]        staging [512];
    logic [7:0]        channels [16][512];
    logic [9:0]        stored_length [16];
    arp_pkg::result_t  due_results [$];
    int                errors;

    function new();
      position = '0;
      reject   = arp_pkg::V_OK;
      universe = '0;
      length   = '0;
      errors   = 0;
      foreach (stored_length[u]) stored_length[u] = '0;
      foreach (staging[c]) staging[c] = '0;
      foreach (channels[u, c]) channels[u][c] = '0;
    endfunction

    // Keep only the first header fault of a packet
    function void flag_reject(arp_pkg::verdict_t code);
      if (reject == arp_pkg::V_OK) reject = code;
    endfunction

    function void take_word(logic f, logic [7:0] b, logic eop, logic [3:0] ru,
                            logic [8:0] rc);
      arp_pkg::result_t  r;
      arp_pkg::verdict_t v;
      int                n;
      int                k;
      int                i;
      r = '0;
      // Serve a read at once from the committed bank
      if (f == arp_pkg::FUNC_READ) begin
        r.kind = arp_pkg::KIND_READ;
        if (rc < stored_length[ru]) r.value = channels[ru][rc];
        due_results.insert(due_results.size(), r);
        return;
      end
      // Check the header as it streams in, stage channel bytes after it
      if (position < arp_pkg::ID_BYTES) begin
        if (b != arp_pkg::ART_ID[position[2:0]]) flag_reject(arp_pkg::V_ID);
      end else if (position == arp_pkg::POS_OPC_LO) begin
        if (b != arp_pkg::OPCODE_LO) flag_reject(arp_pkg::V_OPCODE);
      end else if (position == arp_pkg::POS_OPC_HI) begin
        if (b != arp_pkg::OPCODE_HI) flag_reject(arp_pkg::V_OPCODE);
      end else if (position == arp_pkg::POS_UNIV) begin
        universe = b[3:0];
      end else if (position == arp_pkg::POS_LEN_HI) begin
        length = {2'b00, b};
      end else if (position == arp_pkg::POS_LEN_LO) begin
        n = {length[7:0], b};
        if (n < 2 || n > 512) begin
          flag_reject(arp_pkg::V_LENGTH);
          length = '0;
        end else begin
          length = n[9:0];
        end
      end else if (position >= arp_pkg::HDR_BYTES && reject == arp_pkg::V_OK) begin
        k = position - arp_pkg::HDR_BYTES;
        if (k < length) staging[k] = b;
      end
      if (position < arp_pkg::POS_MAX) position++;
      if (!eop) return;
      // Judge the packet and commit it only when accepted
      if (position < arp_pkg::HDR_BYTES) v = arp_pkg::V_SHORT;
      else if (reject != arp_pkg::V_OK) v = reject;
      else if (int'(position) < int'(arp_pkg::HDR_BYTES) + int'(length)) v = arp_pkg::V_TRUNC;
      else v = arp_pkg::V_OK;
      r.kind    = arp_pkg::KIND_VERDICT;
      r.verdict = v;
      if (v == arp_pkg::V_OK) begin
        r.universe = universe;
        r.length   = length;
        for (i = 0; i < length; i++) channels[universe][i] = staging[i];
        stored_length[universe] = length;
      end
      due_results.insert(due_results.size(), r);
      position = '0;
      reject   = arp_pkg::V_OK;
      universe = '0;
      length   = '0;
    endfunction

    function void compare_field(string name, logic [9:0] want, logic [9:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic kind, logic [2:0] verd, logic [3:0] uni,
                               logic [9:0] len, logic [7:0] val);
      arp_pkg::result_t e;
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result word: expected none, actual kind %0d verdict %0d",
                 $time, kind, verd);
        $display("  universe %0d length %0d value %0d", uni, len, val);
        errors++;
        return;
      end
      e = due_results.pop_front();
      compare_field("result_kind", e.kind, kind);
      compare_field("verdict", e.verdict, verd);
      compare_field("packet_universe", e.universe, uni);
      compare_field("packet_length", e.length, len);
      compare_field("channel_value", e.value, val);
    endfunction
  endclass

  logic       clk;
  logic       rst = 1'b1;
  logic       item_valid = 1'b0;
  logic       item_ready;
  logic       func = arp_pkg::FUNC_BYTE;
  logic [7:0] payload_byte = '0;
  logic       end_of_packet = 1'b0;
  logic [3:0] read_universe = '0;
  logic [8:0] read_channel = '0;
  logic       result_valid;
  logic       result_ready = 1'b0;
  logic       result_kind;
  logic [2:0] verdict;
  logic [3:0] packet_universe;
  logic [9:0] packet_length;
  logic [7:0] channel_value;

  universe_mirror mirror;
  bit             no_idle = 1'b0;
  int             words_sent = 0;
  int             idle_cycles = 0;
  int             ready_wait = 0;
  logic [7:0]     pkt [$];

  artdmx_packet_receiver uut (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item_ready      (item_ready),
    .func            (func),
    .payload_byte    (payload_byte),
    .end_of_packet   (end_of_packet),
    .read_universe   (read_universe),
    .read_channel    (read_channel),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .result_kind     (result_kind),
    .verdict         (verdict),
    .packet_universe (packet_universe),
    .packet_length   (packet_length),
    .channel_value   (channel_value)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Note accepted words, then check returned ones
  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && item_ready)
        mirror.take_word(func, payload_byte, end_of_packet, read_universe, read_channel);
      if (result_valid && result_ready)
        mirror.check_result(result_kind, verdict, packet_universe, packet_length,
                            channel_value);
    end
  end

  // Stall the result side at random after each returned word, never while no_idle is set
  always @(posedge clk) begin : ready_side
    int stall;
    if (rst) begin
      result_ready <= 1'b0;
      ready_wait   <= 0;
    end else if (ready_wait > 0) begin
      ready_wait   <= ready_wait - 1;
      result_ready <= (ready_wait == 1);
    end else if (result_valid && result_ready) begin
      stall = no_idle ? 0 : int'($urandom_range(3));
      ready_wait   <= stall;
      result_ready <= (stall == 0);
    end else begin
      result_ready <= 1'b1;
    end
  end

  // End the run when neither side moves a word for too long
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one word after a random gap and hold it until accepted
  task automatic send_word(logic f, logic [7:0] b, logic eop, logic [3:0] ru,
                           logic [8:0] rc);
    int gap;
    gap = no_idle ? 0 : int'($urandom_range(3));
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid    <= 1'b1;
    func          <= f;
    payload_byte  <= b;
    end_of_packet <= eop;
    read_universe <= ru;
    read_channel  <= rc;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_read(logic [3:0] ru, logic [8:0] rc);
    send_word(arp_pkg::FUNC_READ, 8'($urandom), 1'($urandom), ru, rc);
  endtask

  // Bias half of the random reads toward the low, usually stored channels
  task automatic random_read();
    send_read(4'($urandom_range(15)),
              $urandom_range(1) ? 9'($urandom_range(511)) : 9'($urandom_range(23)));
  endtask

  // Append one byte to the packet under construction
  function automatic void add_byte(logic [7:0] b);
    pkt.insert(pkt.size(), b);
  endfunction

  // Build a well-formed header with the given length field and data bytes
  function automatic void make_packet(int univ, int lenfield, int data_bytes);
    int i;
    pkt.delete();
    for (i = 0; i < 8; i++) add_byte(arp_pkg::ART_ID[i]);
    add_byte(arp_pkg::OPCODE_LO);
    add_byte(arp_pkg::OPCODE_HI);
    repeat (4) add_byte(8'($urandom));
    add_byte({4'($urandom), 4'(univ)});
    add_byte(8'($urandom));
    add_byte(8'(lenfield >> 8));
    add_byte(8'(lenfield));
    repeat (data_bytes) add_byte(8'($urandom));
  endfunction

  // Send the packet words, mixing in reads at about one in read_odds
  task automatic send_packet(int read_odds);
    int i;
    for (i = 0; i < pkt.size(); i++) begin
      if (read_odds > 0 && $urandom_range(read_odds - 1) == 0) random_read();
      send_word(arp_pkg::FUNC_BYTE, pkt[i], i == pkt.size() - 1, 4'($urandom),
                9'($urandom));
    end
  endtask

  function automatic void trim_packet(int keep);
    while (pkt.size() > keep) void'(pkt.pop_back());
  endfunction

  initial begin : stimulus
    int univ;
    int len;
    int shape;
    int bad_lengths [4];
    bad_lengths = '{0, 1, 513, 65535};
    mirror = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: reads of empty universes, then the smallest accepted packet
    no_idle = 1'b1;
    send_read(4'd0, 9'd0);
    send_read(4'd15, 9'd511);
    make_packet(3, 2, 2);
    send_packet(0);
    send_read(4'd3, 9'd0);
    send_read(4'd3, 9'd1);
    send_read(4'd3, 9'd2);
    no_idle = 1'b0;

    // Largest packet, with both byte extremes in the data
    make_packet(15, 512, 512);
    pkt[18]  = 8'hFF;
    pkt[529] = 8'h00;
    send_packet(0);
    send_read(4'd15, 9'd0);
    send_read(4'd15, 9'd511);

    // Short: a lone word, and 17 words whose id is also wrong
    pkt.delete();
    add_byte(8'h41);
    send_packet(0);
    make_packet(0, 2, 2);
    pkt[0] = 8'h00;
    trim_packet(17);
    send_packet(0);

    // Bad id ahead of bad opcode, then bad opcode alone
    make_packet(1, 2, 0);
    pkt[7] = 8'h20;
    pkt[8] = 8'h01;
    send_packet(0);
    make_packet(1, 2, 0);
    pkt[9] = 8'h51;
    send_packet(0);

    // Length field out of range on both sides
    foreach (bad_lengths[i]) begin
      make_packet(2, bad_lengths[i], 0);
      send_packet(0);
    end

    // Truncated packets leave the committed bank as it was
    make_packet(3, 10, 5);
    send_packet(0);
    send_read(4'd3, 9'd1);
    make_packet(4, 2, 0);
    send_packet(0);

    // Trailing bytes past the declared length are dropped
    make_packet(6, 4, 10);
    send_packet(0);
    send_read(4'd6, 9'd3);
    send_read(4'd6, 9'd4);

    // A shorter packet over a longer one cuts the readable range
    make_packet(15, 2, 2);
    send_packet(0);
    send_read(4'd15, 9'd1);
    send_read(4'd15, 9'd100);

    // Reads served in the middle of a packet
    make_packet(8, 6, 6);
    send_packet(3);
    send_read(4'd8, 9'd5);

    // Random: mostly well-formed packets, the rest broken or noise
    while (words_sent < TOTAL_WORDS) begin
      if ($urandom_range(9) == 0) no_idle = !no_idle;
      if ($urandom_range(99) < 25) begin
        random_read();
      end else begin
        univ  = $urandom_range(15);
        len   = ($urandom_range(19) == 0) ? $urandom_range(512, 2) : $urandom_range(24, 2);
        shape = $urandom_range(99);
        if (shape < 65) begin
          make_packet(univ, len, len + (($urandom_range(3) == 0) ? $urandom_range(4, 1) : 0));
        end else if (shape < 72) begin
          // Flip one bit of the id or opcode
          make_packet(univ, len, len);
          pkt[$urandom_range(9)] ^= 8'(1 << $urandom_range(7));
        end else if (shape < 79) begin
          make_packet(univ, $urandom_range(1) ? $urandom_range(1) : $urandom_range(65535, 513),
                      $urandom_range(8));
        end else if (shape < 86) begin
          make_packet(univ, len, $urandom_range(len - 1));
        end else if (shape < 93) begin
          make_packet(univ, len, len);
          trim_packet($urandom_range(17, 1));
        end else begin
          pkt.delete();
          repeat ($urandom_range(40, 1)) add_byte(8'($urandom));
        end
        send_packet(($urandom_range(3) == 0) ? 6 : 0);
      end
    end

    // Drain outstanding results, then let the pipeline settle
    item_valid <= 1'b0;
    do @(posedge clk); while (mirror.due_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mirror.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+design
design/arp_pkg.sv
design/arp_parser.sv
design/arp_dir.sv
design/arp_bank_mem.sv
design/arp_out_fifo.sv
design/artdmx_packet_receiver.sv
tb/testbench.sv
